/* src/svt_pkg.sv */
// shared types, constants and codes for the segmented vector table
package svt_pkg;
   localparam int SEGMENTS     = 10;
   localparam int MAX_CAPACITY = 16;
   localparam int DATA_WIDTH   = 32;
   localparam int SEG_W   = $clog2(SEGMENTS);
   localparam int SLOT_W  = $clog2(MAX_CAPACITY);
   localparam int CNT_W   = $clog2(MAX_CAPACITY + 1);
   localparam int DEPTH   = SEGMENTS * MAX_CAPACITY;
   localparam int ADDR_W  = $clog2(DEPTH);

   typedef enum logic [2:0] {
      REQ_CREATE = 3'd0, REQ_APPEND = 3'd1, REQ_POP = 3'd2,
      REQ_REMOVE = 3'd3, REQ_RESIZE = 3'd4, REQ_READ = 3'd5
   } req_code_type;

   typedef enum logic [3:0] {
      ST_OK = 4'd0, ST_BAD_POS = 4'd1, ST_BAD_SIZE = 4'd2, ST_EXISTS = 4'd3,
      ST_NONE = 4'd4, ST_FULL = 4'd5, ST_EMPTY = 4'd6, ST_NOT_FOUND = 4'd7,
      ST_BAD_NEW = 4'd8, ST_NO_MEM = 4'd9
   } status_code_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [3:0]         segment;
      logic signed [31:0] item_value;
      logic signed [15:0] size_amount;
   } req_type_type;

   typedef struct packed {
      logic [3:0]         status;
      logic [4:0]         element_count;
      logic signed [31:0] element_value;
      logic               element_valid;
      logic               last;
   } rsp_type_type;

   typedef enum logic [2:0] {
      S_IDLE, S_DECIDE, S_SEARCH, S_SHIFT, S_READ, S_RESP
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;       // capture request
      logic decide;     // apply single-step requests, form status
      logic search_rd;  // issue read at index
      logic shift_wr;   // write shifted entry
      logic finish_rm;  // commit removal
      logic not_found;  // report not found
      logic read_rd;    // issue read-out read
      logic emit;       // place result in output register
      logic idx_inc;    // advance index
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic go_search;
      logic go_read;
      logic idx_last;   // index is last valid entry
      logic match;      // read data equals value
      logic found;      // match already seen
   } stat_type;
endpackage

/* src/svt_datapath.sv */
// segment tables, element memory and result register
module svt_datapath import svt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_type_type req_in,
   input  cmd_type      cmd,
   output stat_type     stat,
   output rsp_type_type rsp_out
);
   logic [SEGMENTS-1:0] exists_ff;
   logic [CNT_W-1:0]    cap_ff [SEGMENTS];
   logic [CNT_W-1:0]    cnt_ff [SEGMENTS];
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   req_type_type        req_ff;
   logic [SEG_W-1:0]    s;
   logic                pos_ok;
   logic [CNT_W-1:0]    idx_ff;
   logic [CNT_W-1:0]    rd_idx_ff;
   logic                found_ff;
   logic [3:0]          st_ff;
   logic [CNT_W-1:0]    ocnt_ff;
   logic [CNT_W-1:0]    cnt_cur, cap_cur;
   logic [ADDR_W-1:0]   base;
   logic signed [17:0]  newcap;
   logic                match;
   logic [DATA_WIDTH-1:0] val_w;
   status_code_type     dec_st;
   logic [CNT_W-1:0]    dec_ocnt;
   logic [CNT_W-1:0]    dec_cap;
   logic [CNT_W-1:0]    dec_len;
   logic                dec_tbl_wr;
   logic                dec_create;

   assign pos_ok  = (req_ff.segment >= 4'd1) && ({1'b0, req_ff.segment} <= 5'(SEGMENTS))
                    && (req_ff.req_type <= REQ_READ);
   assign s       = SEG_W'(req_ff.segment - 4'd1);
   assign cnt_cur = cnt_ff[s];
   assign cap_cur = cap_ff[s];
   assign base    = ADDR_W'(s) * ADDR_W'(MAX_CAPACITY);
   assign newcap  = 18'(signed'({1'b0, cap_cur})) + 18'(req_ff.size_amount);
   assign val_w   = DATA_WIDTH'(req_ff.item_value);
   assign match   = (rdata_ff == val_w);

   assign stat.go_search = pos_ok && exists_ff[s] && req_ff.req_type == REQ_REMOVE
                           && cnt_cur != '0;
   assign stat.go_read   = pos_ok && exists_ff[s] && req_ff.req_type == REQ_READ
                           && cnt_cur != '0;
   assign stat.idx_last  = (idx_ff + 1'b1 >= cnt_cur);
   assign stat.match     = match;
   assign stat.found     = found_ff;

   // request capture and index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_in;
      end
      rd_idx_ff <= idx_ff;
      if (cmd.load) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.shift_wr) begin
            found_ff <= 1'b1;
         end
      end
   end

   // element memory: one read, one write port
   always_ff @(posedge clock) begin
      if (cmd.search_rd || cmd.read_rd) begin
         rdata_ff <= mem[base + ADDR_W'(idx_ff)];
      end
      if (cmd.decide && pos_ok && exists_ff[s] && req_ff.req_type == REQ_APPEND
          && cnt_cur < cap_cur) begin
         mem[base + ADDR_W'(cnt_cur)] <= val_w;
      end else if (cmd.shift_wr && found_ff) begin
         mem[base + ADDR_W'(rd_idx_ff) - 1'b1] <= rdata_ff;
      end
   end

   // status and table update for single-step requests
   always_comb begin
      dec_st     = ST_OK;
      dec_ocnt   = pos_ok ? cnt_cur : '0;
      dec_cap    = cap_cur;
      dec_len    = cnt_cur;
      dec_tbl_wr = 1'b0;
      dec_create = 1'b0;
      if (!pos_ok) begin
         dec_st = ST_BAD_POS;
      end else if (req_ff.req_type == REQ_CREATE) begin
         if (req_ff.size_amount < 16'sd1) begin
            dec_st = ST_BAD_SIZE;
         end else if (exists_ff[s]) begin
            dec_st = ST_EXISTS;
         end else if (req_ff.size_amount > 16'(MAX_CAPACITY)) begin
            dec_st = ST_NO_MEM;
         end else begin
            dec_create = 1'b1;
            dec_tbl_wr = 1'b1;
            dec_cap    = CNT_W'(req_ff.size_amount);
            dec_len    = '0;
            dec_ocnt   = '0;
         end
      end else if (!exists_ff[s]) begin
         dec_st = ST_NONE;
      end else begin
         unique case (req_ff.req_type)
            REQ_APPEND: begin
               if (cnt_cur >= cap_cur) begin
                  dec_st = ST_FULL;
               end else begin
                  dec_tbl_wr = 1'b1;
                  dec_len    = cnt_cur + 1'b1;
                  dec_ocnt   = cnt_cur + 1'b1;
               end
            end
            REQ_POP, REQ_REMOVE: begin
               if (cnt_cur == '0) begin
                  dec_st = ST_EMPTY;
               end else if (req_ff.req_type == REQ_POP) begin
                  dec_tbl_wr = 1'b1;
                  dec_len    = cnt_cur - 1'b1;
                  dec_ocnt   = cnt_cur - 1'b1;
               end
            end
            REQ_RESIZE: begin
               if (newcap < 18'sd1) begin
                  dec_st = ST_BAD_NEW;
               end else if (newcap > 18'(MAX_CAPACITY)) begin
                  dec_st = ST_NO_MEM;
               end else begin
                  dec_tbl_wr = 1'b1;
                  dec_cap    = CNT_W'(newcap);
                  if (cnt_cur > CNT_W'(newcap)) begin
                     dec_len  = CNT_W'(newcap);
                     dec_ocnt = CNT_W'(newcap);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // segment tables and status
   always_ff @(posedge clock) begin
      if (reset) begin
         exists_ff <= '0;
         for (int k = 0; k < SEGMENTS; k++) begin
            cap_ff[k] <= '0;
            cnt_ff[k] <= '0;
         end
      end else if (cmd.decide) begin
         ocnt_ff <= dec_ocnt;
         st_ff   <= dec_st;
         if (dec_create) begin
            exists_ff[s] <= 1'b1;
         end
         if (dec_tbl_wr) begin
            cap_ff[s] <= dec_cap;
            cnt_ff[s] <= dec_len;
         end
      end else if (cmd.finish_rm) begin
         cnt_ff[s] <= cnt_cur - 1'b1;
         ocnt_ff   <= cnt_cur - 1'b1;
      end else if (cmd.not_found) begin
         st_ff <= ST_NOT_FOUND;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_out.status        <= st_ff;
         rsp_out.element_count <= 5'(ocnt_ff);
         if (cmd.read_rd || !stat.go_read) begin
            rsp_out.element_value <= '0;
            rsp_out.element_valid <= 1'b0;
            rsp_out.last          <= 1'b1;
         end else begin
            rsp_out.element_value <= 32'(signed'(rdata_ff));
            rsp_out.element_valid <= 1'b1;
            rsp_out.last          <= (rd_idx_ff + 1'b1 >= cnt_cur);
         end
      end
   end
endmodule

/* src/svt_control.sv */
// sequencer for request decode, search/shift and read-out
module svt_control import svt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);
   state_type state_ff, state_in;
   logic      out_full_ff, out_full_in;
   logic      can_emit;

   assign can_emit = !out_full_ff || rsp_ready;
   assign rsp_valid = out_full_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_DECIDE;
         S_DECIDE: begin
            if (stat.go_search || stat.go_read) state_in = S_SEARCH;
            else                                state_in = S_RESP;
         end
         // fetch one entry, then compare/shift or emit it
         S_SEARCH: begin
            if (stat.go_read) state_in = S_READ;
            else              state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (stat.idx_last) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_READ: begin
            if (can_emit && stat.idx_last) state_in = S_IDLE;
            else if (can_emit)             state_in = S_SEARCH;
         end
         S_RESP:   if (can_emit) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      req_ready   = (state_ff == S_IDLE);
      out_full_in = out_full_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE:   cmd.load = req_valid;
         S_DECIDE: begin
            cmd.decide = 1'b1;
         end
         S_SEARCH: begin
            cmd.search_rd = !stat.go_read;
            cmd.read_rd   = stat.go_read;
         end
         S_SHIFT: begin
            cmd.shift_wr  = stat.found || stat.match;
            cmd.idx_inc   = 1'b1;
            if (stat.idx_last) begin
               cmd.finish_rm = stat.found || stat.match;
               cmd.not_found = !(stat.found || stat.match);
            end
         end
         S_READ: begin
            if (can_emit) begin
               cmd.emit    = 1'b1;
               cmd.idx_inc = 1'b1;
               out_full_in = 1'b1;
            end
         end
         S_RESP: begin
            if (can_emit && !stat.go_read) begin
               cmd.emit    = 1'b1;
               out_full_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_full_ff <= out_full_in;
      end
   end
endmodule

/* src/segmented_vector_table.sv */
// segmented vector table top level
// single-step requests: decide, then emit the result; the next request is taken only after emit
// remove value: one memory read and one write slot per entry
// read out: each element is fetched, then emitted, stalled by rsp_ready
// reset clears segment flags, capacities and counts; store is not cleared
module segmented_vector_table import svt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type_type rsp_data
);
   cmd_type  cmd;
   stat_type stat;

   svt_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .stat, .cmd
   );

   svt_datapath u_dp (
      .clock, .reset, .req_in(req_data), .cmd, .stat, .rsp_out(rsp_data)
   );
endmodule
